@@ rtl/rc4_pkg.sv @@
// shared constants and codes for the rc4 stream cipher core
package rc4_pkg;

   // byte and permutation geometry
   localparam int BYTE_W     = 8;
   localparam int PERM_DEPTH = 256;
   localparam int PERM_AW    = 8;

   // key store geometry
   localparam int MAX_KEY_BYTES = 256;
   localparam int KEY_AW        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int KEY_CW        = $clog2(MAX_KEY_BYTES + 1);

   // operation codes on the request channel
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

endpackage

@@ rtl/rc4_req_if.sv @@
// request channel: key and data beats into the cipher core
interface rc4_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [rc4_pkg::BYTE_W-1:0] byte_value;
   logic                      last_key_byte;

   modport source (output valid, output operation, output byte_value,
                   output last_key_byte, input ready);
   modport sink   (input valid, input operation, input byte_value,
                   input last_key_byte, output ready);
endinterface

@@ rtl/rc4_rsp_if.sv @@
// response channel: cipher output beats from the core
interface rc4_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rc4_pkg::BYTE_W-1:0] data_out;
   logic                      no_key;

   modport source (output valid, output data_out, output no_key, input ready);
   modport sink   (input valid, input data_out, input no_key, output ready);
endinterface

@@ rtl/rc4_ram.sv @@
// generic single-write, single-read ram with registered read data
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rc4_stream_cipher_core.sv @@
// rc4 core: a keyed data beat takes 4 steps after accept (d_rdj, d_swap, d_wr2, d_out;
// the last loads the output register), and no new beat is taken until the core is idle again;
// a data beat before any key passes through unchanged; a key beat is stored on accept while there is room.
// the last key beat runs the key schedule, one swap per entry over 256 entries,
// no beats accepted meanwhile; a held result stalls the next beat.
// reset is synchronous: permutation reads as identity through per-entry valid bits,
// indices, key count and keyed flag clear at once, so beats are taken right away.
module rc4_stream_cipher_core (
   input  logic       clock,
   input  logic       reset,
   rc4_req_if.sink    req_ch,
   rc4_rsp_if.source  rsp_ch
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_D_RDJ,
      ST_D_SWAP,
      ST_D_WR2,
      ST_D_OUT,
      ST_K_RD,
      ST_K_J,
      ST_K_WR1,
      ST_K_WR2
   } state_type;

   state_type state_ff;

   logic [rc4_pkg::PERM_AW-1:0] i_ff;
   logic [rc4_pkg::PERM_AW-1:0] j_ff;
   logic [rc4_pkg::PERM_AW-1:0] n_ff;
   logic [rc4_pkg::BYTE_W-1:0]  si_ff;
   logic [rc4_pkg::BYTE_W-1:0]  sj_ff;
   logic [rc4_pkg::BYTE_W-1:0]  value_ff;
   logic                        fwd_ff;
   logic                        keyed_ff;
   logic [rc4_pkg::KEY_CW-1:0]  key_count_ff;
   logic [rc4_pkg::KEY_CW-1:0]  key_len_ff;
   logic [rc4_pkg::KEY_AW-1:0]  kidx_ff;
   logic [rc4_pkg::PERM_DEPTH-1:0] perm_valid_ff;
   logic                        rd_valid_ff;
   logic [rc4_pkg::PERM_AW-1:0] rd_addr_ff;
   logic                        rsp_valid_ff;
   logic [rc4_pkg::BYTE_W-1:0]  rsp_data_ff;
   logic                        rsp_no_key_ff;

   logic                        perm_wr_en;
   logic [rc4_pkg::PERM_AW-1:0] perm_wr_addr;
   logic [rc4_pkg::BYTE_W-1:0]  perm_wr_data;
   logic                        perm_rd_en;
   logic [rc4_pkg::PERM_AW-1:0] perm_rd_addr;
   logic [rc4_pkg::BYTE_W-1:0]  perm_rd_data;
   logic [rc4_pkg::BYTE_W-1:0]  perm_q;

   logic                        key_wr_en;
   logic                        key_rd_en;
   logic [rc4_pkg::BYTE_W-1:0]  key_rd_data;

   logic                        req_accept;
   logic                        is_data;
   logic                        key_room;
   logic                        slot_free;
   logic                        rsp_load;
   logic [rc4_pkg::KEY_CW-1:0]  key_count_next;
   logic [rc4_pkg::KEY_CW-1:0]  kidx_inc;
   logic [rc4_pkg::BYTE_W-1:0]  ks_byte;

   // handshake and shared decode
   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign req_accept     = req_ch.valid && req_ch.ready;
   assign is_data        = (req_ch.operation == rc4_pkg::OP_DATA);
   assign key_room       = (key_count_ff < rc4_pkg::KEY_CW'(rc4_pkg::MAX_KEY_BYTES));
   assign key_count_next = key_room ? (key_count_ff + rc4_pkg::KEY_CW'(1)) : key_count_ff;
   assign kidx_inc       = rc4_pkg::KEY_CW'(kidx_ff) + rc4_pkg::KEY_CW'(1);
   assign slot_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load       = slot_free && ((state_ff == ST_PASS) || (state_ff == ST_D_OUT));

   // entries never written since the last clear read as their own index
   assign perm_q  = rd_valid_ff ? perm_rd_data : rd_addr_ff;
   assign ks_byte = fwd_ff ? si_ff : perm_q;

   // key store write straight from the accepted key beat
   assign key_wr_en = req_accept && !is_data && key_room;
   assign key_rd_en = (state_ff == ST_K_RD);

   // permutation ram port control
   always_comb begin
      perm_wr_en   = 1'b0;
      perm_wr_addr = '0;
      perm_wr_data = '0;
      perm_rd_en   = 1'b0;
      perm_rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            perm_rd_en   = req_accept && is_data && keyed_ff;
            perm_rd_addr = i_ff + rc4_pkg::PERM_AW'(1);
         end
         ST_D_RDJ: begin
            perm_rd_en   = 1'b1;
            perm_rd_addr = j_ff + perm_q;
         end
         ST_D_SWAP: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = i_ff;
            perm_wr_data = perm_q;
         end
         ST_D_WR2: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = j_ff;
            perm_wr_data = si_ff;
            perm_rd_en   = 1'b1;
            perm_rd_addr = si_ff + sj_ff;
         end
         ST_K_RD: begin
            perm_rd_en   = 1'b1;
            perm_rd_addr = n_ff;
         end
         ST_K_J: begin
            perm_rd_en   = 1'b1;
            perm_rd_addr = j_ff + perm_q + key_rd_data;
         end
         ST_K_WR1: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = n_ff;
            perm_wr_data = perm_q;
         end
         ST_K_WR2: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = j_ff;
            perm_wr_data = si_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer, indices and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         keyed_ff      <= 1'b0;
         key_count_ff  <= '0;
         perm_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (perm_wr_en) begin
            perm_valid_ff[perm_wr_addr] <= 1'b1;
         end
         if (perm_rd_en) begin
            rd_valid_ff <= perm_valid_ff[perm_rd_addr];
            rd_addr_ff  <= perm_rd_addr;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (is_data) begin
                     value_ff <= req_ch.byte_value;
                     if (keyed_ff) begin
                        i_ff     <= i_ff + rc4_pkg::PERM_AW'(1);
                        state_ff <= ST_D_RDJ;
                     end else begin
                        state_ff <= ST_PASS;
                     end
                  end else begin
                     key_count_ff <= key_count_next;
                     if (req_ch.last_key_byte) begin
                        // start key schedule from the identity permutation
                        key_len_ff    <= key_count_next;
                        perm_valid_ff <= '0;
                        n_ff          <= '0;
                        j_ff          <= '0;
                        kidx_ff       <= '0;
                        state_ff      <= ST_K_RD;
                     end
                  end
               end
            end
            ST_PASS: begin
               if (slot_free) begin
                  rsp_data_ff   <= value_ff;
                  rsp_no_key_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            // data beat: s[i] read back, advance j
            ST_D_RDJ: begin
               si_ff    <= perm_q;
               j_ff     <= j_ff + perm_q;
               state_ff <= ST_D_SWAP;
            end
            ST_D_SWAP: begin
               sj_ff    <= perm_q;
               state_ff <= ST_D_WR2;
            end
            // keystream read overlaps the s[j] write, so forward on a hit
            ST_D_WR2: begin
               fwd_ff   <= ((si_ff + sj_ff) == j_ff);
               state_ff <= ST_D_OUT;
            end
            ST_D_OUT: begin
               if (slot_free) begin
                  rsp_data_ff   <= value_ff ^ ks_byte;
                  rsp_no_key_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            // key schedule: one swap per entry, through k_rd, k_j, k_wr1 and k_wr2
            ST_K_RD: begin
               state_ff <= ST_K_J;
            end
            ST_K_J: begin
               si_ff <= perm_q;
               j_ff  <= j_ff + perm_q + key_rd_data;
               if (kidx_inc == key_len_ff) begin
                  kidx_ff <= '0;
               end else begin
                  kidx_ff <= kidx_inc[rc4_pkg::KEY_AW-1:0];
               end
               state_ff <= ST_K_WR1;
            end
            ST_K_WR1: begin
               state_ff <= ST_K_WR2;
            end
            ST_K_WR2: begin
               n_ff <= n_ff + rc4_pkg::PERM_AW'(1);
               if (n_ff == rc4_pkg::PERM_AW'(rc4_pkg::PERM_DEPTH - 1)) begin
                  i_ff         <= '0;
                  j_ff         <= '0;
                  key_count_ff <= '0;
                  keyed_ff     <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_K_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.data_out = rsp_data_ff;
   assign rsp_ch.no_key   = rsp_no_key_ff;

   // permutation store
   rc4_ram #(
      .WIDTH (rc4_pkg::BYTE_W),
      .DEPTH (rc4_pkg::PERM_DEPTH)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_wr_en),
      .wr_addr (perm_wr_addr),
      .wr_data (perm_wr_data),
      .rd_en   (perm_rd_en),
      .rd_addr (perm_rd_addr),
      .rd_data (perm_rd_data)
   );

   // key store
   rc4_ram #(
      .WIDTH (rc4_pkg::BYTE_W),
      .DEPTH (rc4_pkg::MAX_KEY_BYTES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_count_ff[rc4_pkg::KEY_AW-1:0]),
      .wr_data (req_ch.byte_value),
      .rd_en   (key_rd_en),
      .rd_addr (kidx_ff),
      .rd_data (key_rd_data)
   );

endmodule
